[src/bhpq_pkg.sv]
// bhpq_pkg: shared widths, command codes, entry type and compare rule
// for the binary heap priority queue; no dependencies
package bhpq_pkg;

    localparam int unsigned CAPACITY_DEF = 256;
    localparam int unsigned KEY_W        = 32;
    localparam int unsigned PAY_W        = 16;
    localparam int unsigned CMD_W        = 2;
    localparam int unsigned CNT_OUT_W    = 9;

    localparam logic [CMD_W-1:0] CMD_INSERT  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_EXTRACT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK    = 2'd2;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [PAY_W-1:0]        payload;
    } t_entry;

    // true when the upper entry has to move below the lower one
    function automatic logic must_swap(
        input logic signed [KEY_W-1:0] upper_key,
        input logic signed [KEY_W-1:0] lower_key,
        input logic                    max_mode
    );
        return max_mode ? (upper_key < lower_key) : (upper_key > lower_key);
    endfunction

endpackage

[src/bhpq_if.sv]
// bhpq_req_if / bhpq_rsp_if: valid/ready channels for commands and results
// depends on bhpq_pkg
interface bhpq_req_if import bhpq_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [CMD_W-1:0]        cmd;
    logic signed [KEY_W-1:0] key;
    logic [PAY_W-1:0]        payload;

    modport source (output valid, output cmd, output key, output payload, input ready);
    modport sink   (input valid, input cmd, input key, input payload, output ready);
endinterface

interface bhpq_rsp_if import bhpq_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [KEY_W-1:0] result_key;
    logic [PAY_W-1:0]        result_payload;
    logic                    found;
    logic                    accepted;
    logic [CNT_OUT_W-1:0]    count_after;

    modport source (output valid, output result_key, output result_payload, output found,
                    output accepted, output count_after, input ready);
    modport sink   (input valid, input result_key, input result_payload, input found,
                    input accepted, input count_after, output ready);
endinterface

[src/binary_heap_priority_queue.sv]
// Binary heap priority queue of up to CAPACITY signed keys with payload tags,
// one command in flight: insert (sift up), extract top (sift down) or peek.
// An insert climbs one level per round and an extract sinks one level per round
// after reading the root and the last entry. A peek, or an extract that leaves
// one entry or none, needs no walk. An insert into an empty heap, a refused
// insert, a read of an empty heap or the unused code goes straight to the result.
// Each level is one read-compare-write round on the entry memory, which is the limit.
// The result register lets the next command start while a result still waits;
// that command holds in its last state until the waiting beat is taken.
// order_mode is taken from i_cfg_wdata when i_cfg_we is high; no clearing pass
// follows reset, the count alone marks which slots are live.
// depends on bhpq_pkg, bhpq_if, bhpq_store and bhpq_ctrl
module binary_heap_priority_queue import bhpq_pkg::*; #(
    parameter int unsigned CAPACITY = CAPACITY_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    bhpq_req_if.sink    i_req,
    bhpq_rsp_if.source  o_rsp
);

    localparam int unsigned AW = $clog2(CAPACITY);

    logic [AW-1:0] rd_addr_a;
    logic [AW-1:0] rd_addr_b;
    logic [AW-1:0] wr_addr;
    logic          wr_en;
    t_entry        rd_data_a;
    t_entry        rd_data_b;
    t_entry        wr_data;

    bhpq_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (i_req),
        .o_rsp       (o_rsp),
        .o_rd_addr_a (rd_addr_a),
        .o_rd_addr_b (rd_addr_b),
        .i_rd_data_a (rd_data_a),
        .i_rd_data_b (rd_data_b),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data)
    );

    bhpq_store #(
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk       (i_clk),
        .i_rd_addr_a (rd_addr_a),
        .i_rd_addr_b (rd_addr_b),
        .o_rd_data_a (rd_data_a),
        .o_rd_data_b (rd_data_b),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (wr_data)
    );

endmodule

[src/bhpq_store.sv]
// bhpq_store: heap entry memory, one write port and two registered read ports
// depends on bhpq_pkg
module bhpq_store import bhpq_pkg::*; #(
    parameter int unsigned DEPTH = CAPACITY_DEF
) (
    input  logic                     i_clk,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_b,
    output t_entry                   o_rd_data_a,
    output t_entry                   o_rd_data_b,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  t_entry                   i_wr_data
);

    t_entry mem [DEPTH];
    t_entry r_rd_a;
    t_entry r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_a <= mem[i_rd_addr_a];
        r_rd_b <= mem[i_rd_addr_b];
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

[src/bhpq_ctrl.sv]
// bhpq_ctrl: command sequencer, sift-up / sift-down walk over the entry memory,
// mode register and result register; depends on bhpq_pkg and bhpq_if
module bhpq_ctrl import bhpq_pkg::*; #(
    parameter int unsigned CAPACITY = CAPACITY_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_wdata,
    bhpq_req_if.sink                    i_req,
    bhpq_rsp_if.source                  o_rsp,
    output logic [$clog2(CAPACITY)-1:0] o_rd_addr_a,
    output logic [$clog2(CAPACITY)-1:0] o_rd_addr_b,
    input  t_entry                      i_rd_data_a,
    input  t_entry                      i_rd_data_b,
    output logic                        o_wr_en,
    output logic [$clog2(CAPACITY)-1:0] o_wr_addr,
    output t_entry                      o_wr_data
);

    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned CW = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {S_IDLE, S_ROOT, S_UP, S_DOWN, S_WR_ITEM, S_FIN} t_state;

    // heap position (from 1) to memory address
    function automatic logic [AW-1:0] slot_addr(input logic [CW+1:0] pos);
        logic [CW+1:0] t;
        t = pos - 1'b1;
        return t[AW-1:0];
    endfunction

    t_state                  r_state, n_state;
    logic                    r_mode;
    logic [CW-1:0]           r_count, n_count;
    logic [CW-1:0]           r_pos, n_pos;
    t_entry                  r_item, n_item;
    logic [CMD_W-1:0]        r_cmd, n_cmd;
    logic signed [KEY_W-1:0] r_res_key, n_res_key;
    logic [PAY_W-1:0]        r_res_pay, n_res_pay;
    logic                    r_found, n_found;
    logic                    r_acc, n_acc;
    logic                    r_ovalid, n_ovalid;
    logic signed [KEY_W-1:0] r_okey, n_okey;
    logic [PAY_W-1:0]        r_opay, n_opay;
    logic                    r_ofound, n_ofound;
    logic                    r_oacc, n_oacc;
    logic [CNT_OUT_W-1:0]    r_ocount, n_ocount;

    logic [CW+1:0] pos_w;
    logic [CW+1:0] cnt_w;
    logic [CW+1:0] left_pos;
    logic [CW+1:0] right_pos;
    logic [CW+1:0] best_pos;
    logic [CW+1:0] next_left;
    logic [CW-1:0] parent_pos;
    t_entry        best;
    t_entry        in_item;
    logic          take_left;

    assign i_req.ready = (r_state == S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_pos     = r_pos;
        n_item    = r_item;
        n_cmd     = r_cmd;
        n_res_key = r_res_key;
        n_res_pay = r_res_pay;
        n_found   = r_found;
        n_acc     = r_acc;
        n_ovalid  = r_ovalid;
        n_okey    = r_okey;
        n_opay    = r_opay;
        n_ofound  = r_ofound;
        n_oacc    = r_oacc;
        n_ocount  = r_ocount;

        pos_w      = (CW+2)'(r_pos);
        cnt_w      = (CW+2)'(r_count);
        left_pos   = {1'b0, r_pos, 1'b0};
        right_pos  = left_pos + 1'b1;
        parent_pos = r_pos >> 1;
        in_item    = '{key: i_req.key, payload: i_req.payload};

        // sift-down pick: left first, right only if strictly better
        take_left = must_swap(r_item.key, i_rd_data_a.key, r_mode);
        best      = take_left ? i_rd_data_a : r_item;
        best_pos  = take_left ? left_pos : pos_w;
        if (right_pos <= cnt_w && must_swap(best.key, i_rd_data_b.key, r_mode)) begin
            best     = i_rd_data_b;
            best_pos = right_pos;
        end
        next_left = {best_pos[CW:0], 1'b0};

        o_rd_addr_a = '0;
        o_rd_addr_b = '0;
        o_wr_en     = 1'b0;
        o_wr_addr   = slot_addr(pos_w);
        o_wr_data   = r_item;

        if (r_ovalid && o_rsp.ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_cmd     = i_req.cmd;
                    n_item    = in_item;
                    n_res_key = '0;
                    n_res_pay = '0;
                    n_found   = 1'b0;
                    n_acc     = 1'b0;
                    n_state   = S_FIN;
                    if (i_req.cmd == CMD_INSERT) begin
                        if (r_count < CW'(CAPACITY)) begin
                            n_acc   = 1'b1;
                            n_count = r_count + 1'b1;
                            n_pos   = r_count + 1'b1;
                            if (r_count == '0) begin
                                o_wr_en   = 1'b1;
                                o_wr_addr = '0;
                                o_wr_data = in_item;
                            end else begin
                                o_rd_addr_a = slot_addr((CW+2)'(n_count >> 1));
                                n_state     = S_UP;
                            end
                        end
                    end else if (i_req.cmd == CMD_EXTRACT || i_req.cmd == CMD_PEEK) begin
                        if (r_count != '0) begin
                            o_rd_addr_b = slot_addr(cnt_w);
                            n_state     = S_ROOT;
                        end
                    end
                end
            end
            S_ROOT: begin
                n_res_key = i_rd_data_a.key;
                n_res_pay = i_rd_data_a.payload;
                n_found   = 1'b1;
                n_state   = S_FIN;
                if (r_cmd == CMD_EXTRACT) begin
                    n_item  = i_rd_data_b;
                    n_count = r_count - 1'b1;
                    n_pos   = CW'(1);
                    if (r_count == CW'(2)) begin
                        o_wr_en   = 1'b1;
                        o_wr_addr = '0;
                        o_wr_data = i_rd_data_b;
                    end else if (r_count > CW'(2)) begin
                        o_rd_addr_a = slot_addr((CW+2)'(2));
                        o_rd_addr_b = slot_addr((CW+2)'(3));
                        n_state     = S_DOWN;
                    end
                end
            end
            S_UP: begin
                o_wr_en = 1'b1;
                if (must_swap(i_rd_data_a.key, r_item.key, r_mode)) begin
                    // parent drops into the hole, hole moves up
                    o_wr_data = i_rd_data_a;
                    n_pos     = parent_pos;
                    if (parent_pos == CW'(1)) begin
                        n_state = S_WR_ITEM;
                    end else begin
                        o_rd_addr_a = slot_addr((CW+2)'(parent_pos >> 1));
                    end
                end else begin
                    n_state = S_FIN;
                end
            end
            S_DOWN: begin
                o_wr_en = 1'b1;
                if (best_pos == pos_w) begin
                    n_state = S_FIN;
                end else begin
                    o_wr_data = best;
                    n_pos     = best_pos[CW-1:0];
                    if (next_left > cnt_w) begin
                        n_state = S_WR_ITEM;
                    end else begin
                        o_rd_addr_a = slot_addr(next_left);
                        o_rd_addr_b = slot_addr(next_left + 1'b1);
                    end
                end
            end
            S_WR_ITEM: begin
                o_wr_en = 1'b1;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_ovalid || o_rsp.ready) begin
                    n_ovalid = 1'b1;
                    n_okey   = r_res_key;
                    n_opay   = r_res_pay;
                    n_ofound = r_found;
                    n_oacc   = r_acc;
                    n_ocount = CNT_OUT_W'(r_count);
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mode   <= 1'b0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
        end
        r_pos     <= n_pos;
        r_item    <= n_item;
        r_cmd     <= n_cmd;
        r_res_key <= n_res_key;
        r_res_pay <= n_res_pay;
        r_found   <= n_found;
        r_acc     <= n_acc;
        r_okey    <= n_okey;
        r_opay    <= n_opay;
        r_ofound  <= n_ofound;
        r_oacc    <= n_oacc;
        r_ocount  <= n_ocount;
    end

    assign o_rsp.valid          = r_ovalid;
    assign o_rsp.result_key     = r_okey;
    assign o_rsp.result_payload = r_opay;
    assign o_rsp.found          = r_ofound;
    assign o_rsp.accepted       = r_oacc;
    assign o_rsp.count_after    = r_ocount;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("item count above capacity");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == $past(r_count) || r_count == $past(r_count) + 1'b1 ||
        r_count == $past(r_count) - 1'b1)
        else $error("item count moved by more than one");

    a_found_xor_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> !(r_ofound && r_oacc))
        else $error("result flags both found and accepted");

    a_no_write_in_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |-> !o_wr_en)
        else $error("memory write while holding a finished result");

    a_result_loads_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && (!r_ovalid || o_rsp.ready)) |=> (r_ovalid && r_state == S_IDLE))
        else $error("finished result not handed to output register");
`endif

endmodule
